// File: src/snm_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and sizes for the som neuron match and update block
package snm_pkg;

	localparam int VECTOR_MAX_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int IDX_RANGE       = 16;

	localparam logic [1:0] ACT_EVAL   = 2'd0;
	localparam logic [1:0] ACT_UPDATE = 2'd1;
	localparam logic [1:0] ACT_LOAD   = 2'd2;

	localparam int ACC_W = 40;
	localparam int SQ_W  = 42;

	typedef struct packed {
		logic [1:0]         op;
		logic               last;
		logic [3:0]         idx;
		logic               in_range;
		logic signed [15:0] x;
		logic [31:0]        g;
	} cmd_t;

endpackage

// File: src/snm_item_if.sv
`timescale 1ns / 1ps
// input item channel
interface snm_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [3:0]         element_index;
	logic signed [15:0] sample_value;
	logic [15:0]        learn_rate;
	logic [15:0]        neighborhood;
	logic               last_element;

	modport source (
		output valid, action, element_index, sample_value, learn_rate, neighborhood,
		last_element,
		input ready
	);
	modport sink (
		input valid, action, element_index, sample_value, learn_rate, neighborhood,
		last_element,
		output ready
	);
endinterface

// File: src/snm_result_if.sv
`timescale 1ns / 1ps
// activation result channel
interface snm_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] activation;

	modport source (output valid, activation, input ready);
	modport sink (input valid, activation, output ready);
endinterface

// File: src/snm_cfg_if.sv
`timescale 1ns / 1ps
// configuration write channel for the mode register
interface snm_cfg_if;
	logic valid;
	logic ready;
	logic distance_mode;

	modport source (output valid, distance_mode, input ready);
	modport sink (input valid, distance_mode, output ready);
endinterface

// File: src/snm_front.sv
`timescale 1ns / 1ps
// front end: accepts items, drops unused codes, precomputes the update gain
module snm_front #(
	parameter int VECTOR_MAX = snm_pkg::VECTOR_MAX_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	snm_item_if.sink      item,
	output logic          cmd_valid,
	output snm_pkg::cmd_t cmd,
	input  logic          cmd_ready
);

	logic          v_s1;
	snm_pkg::cmd_t cmd_s1;
	logic          keep;
	logic          take;

	always_comb begin
		unique case (item.action) inside
			snm_pkg::ACT_EVAL, snm_pkg::ACT_UPDATE, snm_pkg::ACT_LOAD: keep = 1'b1;
			default:                                                 keep = 1'b0;
		endcase
	end

	assign item.ready = !v_s1 || cmd_ready;
	assign take       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op       <= item.action;
			cmd_s1.last     <= item.last_element;
			cmd_s1.idx      <= item.element_index;
			cmd_s1.in_range <= (32'(item.element_index) < VECTOR_MAX);
			cmd_s1.x        <= item.sample_value;
			cmd_s1.g        <= 32'(item.learn_rate) * 32'(item.neighborhood);
		end
	end

	assign cmd_valid = v_s1;
	assign cmd       = cmd_s1;

endmodule

// File: src/snm_fifo.sv
`timescale 1ns / 1ps
// command queue between front and back
module snm_fifo #(
	parameter int DEPTH = snm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  snm_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output snm_pkg::cmd_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	snm_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: src/snm_back.sv
`timescale 1ns / 1ps
// back end: weight store, match accumulator, weight update and square root
module snm_back #(
	parameter int VECTOR_MAX = snm_pkg::VECTOR_MAX_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          distance_mode,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  snm_pkg::cmd_t cmd,
	snm_result_if.source  result
);

	localparam int WDEPTH = (VECTOR_MAX < snm_pkg::IDX_RANGE) ? VECTOR_MAX : snm_pkg::IDX_RANGE;
	localparam int IW     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int AW     = snm_pkg::ACC_W;
	localparam int SW     = snm_pkg::SQ_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_FIN  = 3'd2;
	localparam logic [2:0] S_SQRT = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
	localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

	logic [2:0]           state_q;
	logic signed [15:0]   weight_q [WDEPTH];
	logic signed [AW-1:0] acc_q;
	logic signed [33:0]   term_q;
	logic signed [49:0]   prod_q;
	logic signed [15:0]   w_q;
	logic [1:0]           op_q;
	logic                 last_q;
	logic [3:0]           idx_q;
	logic                 in_range_q;
	logic [SW-1:0]        sq_n_q;
	logic [SW-1:0]        sq_root_q;
	logic [SW-1:0]        sq_bit_q;
	logic [31:0]          res_q;
	logic                 out_valid_q;
	logic [31:0]          out_q;

	logic signed [15:0]   w_rd;
	logic signed [16:0]   d_rd;
	logic signed [16:0]   mul_a;
	logic signed [16:0]   mul_b;
	logic signed [33:0]   term_c;
	logic signed [49:0]   prod_c;
	logic signed [AW:0]   acc_sum;
	logic signed [AW-1:0] acc_sat;
	logic signed [49:0]   prod_rnd;
	logic signed [17:0]   step;
	logic signed [18:0]   w_new;
	logic signed [15:0]   w_sat;
	logic signed [AW:0]   dot_c;
	logic [SW-1:0]        sq_t;
	logic                 sq_ge;
	logic [SW-1:0]        sq_root_nx;
	logic                 out_free;
	logic                 pop;

	assign w_rd   = cmd.in_range ? weight_q[cmd.idx[IW-1:0]] : 16'sd0;
	assign d_rd   = {cmd.x[15], cmd.x} - {w_rd[15], w_rd};
	assign mul_a  = distance_mode ? d_rd : {cmd.x[15], cmd.x};
	assign mul_b  = distance_mode ? d_rd : {w_rd[15], w_rd};
	assign term_c = 34'(mul_a) * 34'(mul_b);
	assign prod_c = 50'(d_rd) * $signed({18'b0, cmd.g});

	assign acc_sum = {acc_q[AW-1], acc_q} + (AW+1)'(term_q);
	always_comb begin
		if (acc_sum > (AW+1)'(ACC_MAX)) begin
			acc_sat = ACC_MAX;
		end else if (acc_sum < (AW+1)'(ACC_MIN)) begin
			acc_sat = ACC_MIN;
		end else begin
			acc_sat = acc_sum[AW-1:0];
		end
	end

	assign prod_rnd = prod_q + (50'sd1 <<< 31);
	assign step     = prod_rnd[49:32];
	assign w_new    = {{3{w_q[15]}}, w_q} + {step[17], step};
	always_comb begin
		if (w_new > 19'sd32767) begin
			w_sat = 16'sh7fff;
		end else if (w_new < -19'sd32768) begin
			w_sat = 16'sh8000;
		end else begin
			w_sat = w_new[15:0];
		end
	end

	assign dot_c = {acc_q[AW-1], acc_q} + (AW+1)'(8192);

	assign sq_t  = sq_root_q + sq_bit_q;
	assign sq_ge = (sq_n_q >= sq_t);
	assign sq_root_nx = sq_ge ? ((sq_root_q >> 1) + sq_bit_q) : (sq_root_q >> 1);

	assign out_free  = !out_valid_q || result.ready;
	assign cmd_ready = (state_q == S_IDLE);
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WDEPTH; i++) begin
				weight_q[i] <= '0;
			end
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (cmd.op == snm_pkg::ACT_LOAD) begin
							if (cmd.in_range) begin
								weight_q[cmd.idx[IW-1:0]] <= cmd.x;
							end
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					if (op_q == snm_pkg::ACT_UPDATE) begin
						if (in_range_q) begin
							weight_q[idx_q[IW-1:0]] <= w_sat;
						end
						state_q <= S_IDLE;
					end else begin
						acc_q   <= acc_sat;
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					state_q <= distance_mode ? S_SQRT : S_EMIT;
				end
				S_SQRT: begin
					if (sq_bit_q == SW'(1)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						acc_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			term_q     <= term_c;
			prod_q     <= prod_c;
			w_q        <= w_rd;
			op_q       <= cmd.op;
			last_q     <= cmd.last;
			idx_q      <= cmd.idx;
			in_range_q <= cmd.in_range;
		end
		if (state_q == S_FIN) begin
			res_q     <= {{5{dot_c[AW]}}, dot_c[AW:14]};
			sq_n_q    <= acc_q[AW-1] ? '0 : {1'b0, acc_q[AW-2:0], 2'b00};
			sq_root_q <= '0;
			sq_bit_q  <= SW'(1) << (SW - 2);
		end
		if (state_q == S_SQRT) begin
			if (sq_ge) begin
				sq_n_q <= sq_n_q - sq_t;
			end
			sq_root_q <= sq_root_nx;
			sq_bit_q  <= sq_bit_q >> 2;
			res_q     <= 32'(sq_root_nx);
		end
		if (state_q == S_EMIT && out_free) begin
			out_q <= res_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.activation = out_q;

endmodule

// File: src/som_neuron_match_and_update.sv
`timescale 1ns / 1ps
// top level: self-organizing-map neuron, front end, command queue and back end
// an item passes the front register, then the back takes it from the queue
// the back writes a load as it takes it; evaluate and update register the multiply, then write
// a last evaluate then passes the finish and emit states, in distance mode the square root between them
// asynchronous active-low reset clears weights, accumulator, mode, queue and valids
module som_neuron_match_and_update #(
	parameter int VECTOR_MAX  = snm_pkg::VECTOR_MAX_DEF,
	parameter int QUEUE_DEPTH = snm_pkg::QUEUE_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	snm_item_if.sink     item,
	snm_result_if.source result,
	snm_cfg_if.sink      cfg
);

	logic          distance_mode_q;
	logic          fc_valid;
	logic          fc_ready;
	snm_pkg::cmd_t fc_cmd;
	logic          bc_valid;
	logic          bc_ready;
	snm_pkg::cmd_t bc_cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			distance_mode_q <= cfg.distance_mode;
		end
	end

	snm_front #(
		.VECTOR_MAX (VECTOR_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd_valid (fc_valid),
		.cmd       (fc_cmd),
		.cmd_ready (fc_ready)
	);

	snm_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fc_valid),
		.push_ready (fc_ready),
		.push_data  (fc_cmd),
		.pop_valid  (bc_valid),
		.pop_ready  (bc_ready),
		.pop_data   (bc_cmd)
	);

	snm_back #(
		.VECTOR_MAX (VECTOR_MAX)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.distance_mode (distance_mode_q),
		.cmd_valid     (bc_valid),
		.cmd_ready     (bc_ready),
		.cmd           (bc_cmd),
		.result        (result)
	);

endmodule

// File: src/snm_checker.sv
`timescale 1ns / 1ps
// port-level checks on the som neuron top level, with its bind
module snm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic [1:0]  item_action,
	input logic        item_last,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] result_activation,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        cfg_distance_mode
);

	logic [7:0] pend_q;
	logic       dist_q;
	logic       inc;
	logic       dec;

	assign inc = item_valid && item_ready && (item_action == snm_pkg::ACT_EVAL) && item_last;
	assign dec = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			dist_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 8'(inc) - 8'(dec);
			if (cfg_valid && cfg_ready) begin
				dist_q <= cfg_distance_mode;
			end
		end
	end

	// a result only for a last evaluate word not yet answered
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 8'd0)
		else $error("result without pending last evaluate word");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_activation))
		else $error("stalled result changed");

	// a distance is never negative
	a_dist_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && dist_q |-> !result_activation[31])
		else $error("negative distance");

	// a rounded dot product fits 27 signed bits
	a_dot_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !dist_q |->
			(result_activation[31:26] == 6'h00 || result_activation[31:26] == 6'h3f))
		else $error("dot product out of range");

endmodule

bind som_neuron_match_and_update snm_checker u_snm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.item_action       (item.action),
	.item_last         (item.last_element),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.result_activation (result.activation),
	.cfg_valid         (cfg.valid),
	.cfg_ready         (cfg.ready),
	.cfg_distance_mode (cfg.distance_mode)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for som_neuron_match_and_update with its own neuron predictor
module tb;

	localparam logic [1:0] ACT_UNUSED  = 2'd3;
	localparam logic       MODE_DOT    = 1'b0;
	localparam logic       MODE_DIST   = 1'b1;
	localparam longint     ACC_HI      = 64'sd549755813887;
	localparam longint     ACC_LO      = -ACC_HI - 1;
	localparam longint     ACT_HI      = 64'sd2147483647;
	localparam longint     ACT_LO      = -ACT_HI - 1;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         SETTLE_CYC  = 40;

	typedef struct packed {
		logic [1:0]         action;
		logic [3:0]         idx;
		logic signed [15:0] x;
		logic [15:0]        alpha;
		logic [15:0]        theta;
		logic               last;
	} item_word_t;

	logic clk;
	logic arst_n;

	snm_item_if   item_ch ();
	snm_result_if act_ch ();
	snm_cfg_if    cfg_ch ();

	som_neuron_match_and_update dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (act_ch),
		.cfg    (cfg_ch)
	);

	// predictor state
	logic signed [15:0] weights [snm_pkg::IDX_RANGE];
	longint             accum;
	logic               dist_mode;

	item_word_t         pending_words [$];
	logic signed [31:0] act_due [$];
	logic signed [31:0] due_act;
	logic               item_taken;
	int unsigned        fail_cnt;
	int unsigned        cyc;
	int unsigned        send_idle_pct;
	int unsigned        recv_stall_pct;
	int unsigned        hold_len;
	int unsigned        hold_trig;
	int unsigned        hold_seen;
	int unsigned        hold_cnt;

	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		fail_cnt++;
	endtask

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root;
		longint unsigned probe;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > n)
			probe = probe >> 2;
		while (probe != 0) begin
			if (n >= root + probe) begin
				n = n - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	task automatic apply_word(input item_word_t w);
		longint          xv;
		longint          wv;
		longint          term;
		longint          act;
		longint          stp;
		longint unsigned g;
		longint unsigned s;
		xv = w.x;
		wv = weights[w.idx];
		case (w.action)
			snm_pkg::ACT_EVAL: begin
				term = (dist_mode == MODE_DIST) ? (xv - wv) * (xv - wv) : xv * wv;
				accum = clip(accum + term, ACC_LO, ACC_HI);
				if (w.last) begin
					if (dist_mode == MODE_DIST) begin
						s = (accum > 0) ? accum : 0;
						act = int_sqrt(s * 4);
					end else begin
						act = (accum + 8192) >>> 14;
					end
					act = clip(act, ACT_LO, ACT_HI);
					act_due.push_back(act[31:0]);
					accum = 0;
				end
			end
			snm_pkg::ACT_UPDATE: begin
				g = 64'(w.alpha) * 64'(w.theta);
				stp = ((xv - wv) * longint'(g) + (64'sd1 <<< 31)) >>> 32;
				weights[w.idx] = 16'(clip(wv + stp, -32768, 32767));
			end
			snm_pkg::ACT_LOAD: begin
				weights[w.idx] = w.x;
			end
			default: begin
			end
		endcase
	endtask

	// monitor: mode writes, result checks, prediction on accepted words
	always @(posedge clk) begin
		item_taken <= item_ch.valid && item_ch.ready;
		if (cfg_ch.valid && cfg_ch.ready)
			dist_mode = cfg_ch.distance_mode;
		if (act_ch.valid && act_ch.ready) begin
			if (act_due.size() == 0) begin
				report_mismatch($sformatf("unexpected activation %0d", act_ch.activation));
			end else begin
				due_act = act_due.pop_front();
				if (act_ch.activation !== due_act)
					report_mismatch($sformatf("activation %0d, predicted %0d",
						act_ch.activation, due_act));
			end
		end
		if (item_ch.valid && item_ch.ready) begin
			if (pending_words.size() != 0)
				void'(pending_words.pop_front());
			apply_word({item_ch.action, item_ch.element_index, item_ch.sample_value,
				item_ch.learn_rate, item_ch.neighborhood, item_ch.last_element});
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && (!item_ch.valid || item_taken)) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item_ch.action        <= pending_words[0].action;
				item_ch.element_index <= pending_words[0].idx;
				item_ch.sample_value  <= pending_words[0].x;
				item_ch.learn_rate    <= pending_words[0].alpha;
				item_ch.neighborhood  <= pending_words[0].theta;
				item_ch.last_element  <= pending_words[0].last;
				item_ch.valid         <= 1'b1;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver with long hold-off
	always @(negedge clk) begin
		if (hold_trig != hold_seen) begin
			hold_seen = hold_trig;
			hold_cnt = hold_len;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			act_ch.ready <= 1'b0;
		end else begin
			act_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic push_word(input logic [1:0] a, input logic [3:0] i, input logic [15:0] x,
		input logic [15:0] al, input logic [15:0] th, input logic lst);
		item_word_t w;
		w.action = a;
		w.idx = i;
		w.x = x;
		w.alpha = al;
		w.theta = th;
		w.last = lst;
		pending_words.push_back(w);
	endtask

	function automatic logic [15:0] rand_sample();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return 16'h8000;
		if (r == 1)
			return 16'h7FFF;
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] rand_factor();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return 16'h0000;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	task automatic fill_random(input int unsigned n);
		int unsigned made;
		int unsigned pick;
		int unsigned len;
		logic [1:0]  a;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				len = $urandom_range(1, 16);
				for (int unsigned k = 0; k < len; k++)
					push_word(snm_pkg::ACT_EVAL, (pick < 44) ? 4'(k) : 4'($urandom),
						rand_sample(), 16'($urandom), 16'($urandom), k == len - 1);
				made += len;
			end else if (pick < 70) begin
				len = $urandom_range(1, 8);
				for (int unsigned k = 0; k < len; k++)
					push_word(snm_pkg::ACT_UPDATE, 4'($urandom), rand_sample(), rand_factor(),
						rand_factor(), 1'($urandom));
				made += len;
			end else if (pick < 82) begin
				len = $urandom_range(1, 6);
				for (int unsigned k = 0; k < len; k++)
					push_word(snm_pkg::ACT_LOAD, 4'($urandom), rand_sample(), 16'($urandom),
						16'($urandom), 1'($urandom));
				made += len;
			end else begin
				a = 2'($urandom);
				push_word(a, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					1'($urandom));
				if (a != ACT_UNUSED)
					made++;
			end
		end
	endtask

	// all weights to one value, then one long vector that drives the sum to its bound
	task automatic push_long_run(input int unsigned len, input logic [15:0] wv,
		input logic [15:0] xv);
		for (int unsigned k = 0; k < snm_pkg::IDX_RANGE; k++)
			push_word(snm_pkg::ACT_LOAD, 4'(k), wv, 16'h0, 16'h0, 1'b0);
		for (int unsigned k = 0; k < len; k++)
			push_word(snm_pkg::ACT_EVAL, 4'(k), xv, 16'h0, 16'h0, k == len - 1);
	endtask

	task automatic settle();
		while (pending_words.size() != 0 || item_ch.valid || act_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(negedge clk);
		cfg_ch.distance_mode <= m;
		cfg_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.action = snm_pkg::ACT_EVAL;
		item_ch.element_index = '0;
		item_ch.sample_value = '0;
		item_ch.learn_rate = '0;
		item_ch.neighborhood = '0;
		item_ch.last_element = 1'b0;
		act_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.distance_mode = MODE_DOT;
		item_taken = 1'b0;
		for (int k = 0; k < snm_pkg::IDX_RANGE; k++)
			weights[k] = '0;
		accum = 0;
		dist_mode = MODE_DOT;
		fail_cnt = 0;
		cyc = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_len = 0;
		hold_trig = 0;
		hold_seen = 0;
		hold_cnt = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, dot mode
		push_word(snm_pkg::ACT_EVAL, 4'd0, 16'h7FFF, 16'h0, 16'h0, 1'b1);
		push_word(snm_pkg::ACT_LOAD, 4'd0, 16'h7FFF, 16'h0, 16'h0, 1'b0);
		push_word(snm_pkg::ACT_LOAD, 4'd15, 16'h8000, 16'h0, 16'h0, 1'b0);
		push_word(snm_pkg::ACT_LOAD, 4'd7, 16'hFFFF, 16'h0, 16'h0, 1'b0);
		push_word(snm_pkg::ACT_LOAD, 4'd1, 16'h4000, 16'hFFFF, 16'hFFFF, 1'b1);
		push_word(snm_pkg::ACT_EVAL, 4'd0, 16'h7FFF, 16'h0, 16'h0, 1'b0);
		push_word(snm_pkg::ACT_EVAL, 4'd15, 16'h8000, 16'h0, 16'h0, 1'b0);
		push_word(snm_pkg::ACT_EVAL, 4'd7, 16'h8000, 16'h0, 16'h0, 1'b0);
		push_word(snm_pkg::ACT_EVAL, 4'd1, 16'h0000, 16'h0, 16'h0, 1'b1);
		push_word(snm_pkg::ACT_UPDATE, 4'd0, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b0);
		push_word(snm_pkg::ACT_UPDATE, 4'd15, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b1);
		push_word(snm_pkg::ACT_UPDATE, 4'd7, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b0);
		push_word(snm_pkg::ACT_UPDATE, 4'd1, 16'h8000, 16'h8000, 16'h8000, 1'b0);
		push_word(ACT_UNUSED, 4'd2, 16'h1234, 16'hFFFF, 16'hFFFF, 1'b1);
		push_word(snm_pkg::ACT_EVAL, 4'd15, 16'h8000, 16'h0, 16'h0, 1'b1);
		for (int unsigned k = 0; k < 4; k++)
			push_word(snm_pkg::ACT_EVAL, 4'(k), 16'h7FFF, 16'h0, 16'h0, k == 3);
		settle();
		write_mode(MODE_DIST);

		// directed, distance mode
		push_word(snm_pkg::ACT_EVAL, 4'd15, 16'h7FFF, 16'h0, 16'h0, 1'b1);
		push_word(snm_pkg::ACT_EVAL, 4'd3, 16'h0000, 16'h0, 16'h0, 1'b1);
		push_word(snm_pkg::ACT_EVAL, 4'd0, 16'h8000, 16'h0, 16'h0, 1'b0);
		push_word(snm_pkg::ACT_EVAL, 4'd15, 16'h7FFF, 16'h0, 16'h0, 1'b1);
		push_word(ACT_UNUSED, 4'd15, 16'h7FFF, 16'h0, 16'h0, 1'b1);
		settle();
		write_mode(MODE_DOT);

		// no idling, receiver holds off while the sender keeps offering
		hold_len = 400;
		hold_trig++;
		fill_random(90);
		settle();
		write_mode(MODE_DIST);

		send_idle_pct = 63;
		fill_random(90);
		settle();
		write_mode(MODE_DOT);

		send_idle_pct = 0;
		recv_stall_pct = 63;
		fill_random(50);
		push_long_run(530, 16'h8000, 16'h8000);
		fill_random(50);
		settle();
		write_mode(MODE_DIST);

		send_idle_pct = 38;
		recv_stall_pct = 38;
		fill_random(50);
		push_long_run(140, 16'h8000, 16'h7FFF);
		fill_random(50);
		settle();

		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
src/snm_pkg.sv
src/snm_item_if.sv
src/snm_result_if.sv
src/snm_cfg_if.sv
src/snm_front.sv
src/snm_fifo.sv
src/snm_back.sv
src/som_neuron_match_and_update.sv
src/snm_checker.sv
tb/tb.sv
